@@ hw/rtl/alm_pkg.sv @@
// ----------------------------------------------------------------------------
// alm_pkg
// Shared types and constants of the audio level meter with history.
// ----------------------------------------------------------------------------
package alm_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int LEVEL_W    = 16;
  localparam int COUNT_W    = 9;
  localparam int INDEX_W    = 8;
  localparam int SUM_W      = 32;
  localparam int LCOUNT_W   = 16;
  localparam int DIV_W      = 32;
  localparam int DIV_CNT_W  = 5;
  localparam int MAXH_RESET = 64;

  typedef enum logic [1:0] {
    MODE_SAMPLE = 2'd0,
    MODE_TICK   = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_READ   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    KIND_APPEND = 2'd0,
    KIND_CLEAR  = 2'd1,
    KIND_READ   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLOSE,
    S_LEVEL,
    S_PUT
  } state_t;

  typedef struct packed {
    logic append;
    logic clear;
    logic read;
  } hist_cmd_t;

endpackage

@@ hw/rtl/alm_div.sv @@
// ----------------------------------------------------------------------------
// alm_div
// Restoring divider, one quotient bit per cycle. Quotient valid with done.
// ----------------------------------------------------------------------------
module alm_div
  import alm_pkg::*;
#(
  parameter int DVW = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DVW-1:0]   divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_W-1:0]     quo;
  logic [DVW-1:0]       rem;
  logic [DVW-1:0]       dvs;
  logic [DVW:0]         trial;
  logic                 ge;
  logic [DVW-1:0]       rem_next;

  localparam logic [DIV_CNT_W-1:0] LAST = DIV_CNT_W'(DIV_W - 1);

  always_comb begin
    trial    = {rem, quo[DIV_W-1]};
    ge       = trial >= {1'b0, dvs};
    rem_next = ge ? DVW'(trial - {1'b0, dvs}) : trial[DVW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == LAST) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= '0;
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      quo <= {quo[DIV_W-2:0], ge};
      rem <= rem_next;
    end
  end

  assign quotient = quo;

endmodule

@@ hw/rtl/alm_hist.sv @@
// ----------------------------------------------------------------------------
// alm_hist
// History ring: entry memory with registered read, head pointer and fill.
// ----------------------------------------------------------------------------
module alm_hist
  import alm_pkg::*;
#(
  parameter int DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  hist_cmd_t          cmd,
  input  logic [LEVEL_W-1:0] wdata,
  input  logic [INDEX_W-1:0] index,
  input  logic [COUNT_W-1:0] max_history,
  output logic [LEVEL_W-1:0] rd_level,
  output logic [$clog2(DEPTH+1)-1:0] fill
);

  localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FW  = $clog2(DEPTH + 1);
  localparam int MW  = (FW > COUNT_W) ? FW : COUNT_W;
  localparam int SW0 = (AW > FW) ? AW : FW;
  localparam int SW  = ((SW0 > INDEX_W) ? SW0 : INDEX_W) + 1;
  localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
  localparam logic [MW-1:0] DEPTH_M = MW'(DEPTH);

  logic [LEVEL_W-1:0] mem [DEPTH];
  logic [AW-1:0]      head;
  logic [LEVEL_W-1:0] rdata;
  logic               rd_hit;

  logic [MW-1:0] lim_m;
  logic [FW-1:0] lim;
  logic          full;
  logic [SW-1:0] wsum, hsum, rsum;
  logic [AW-1:0] wr_addr, head_inc, rd_addr;
  logic          hit;

  always_comb begin
    lim_m = (max_history == '0) ? MW'(1) : MW'(max_history);
    if (lim_m > DEPTH_M) begin
      lim_m = DEPTH_M;
    end
    lim  = FW'(lim_m);
    full = fill >= lim;

    wsum = SW'(head) + SW'(fill);
    hsum = SW'(head) + SW'(1);
    rsum = SW'(head) + SW'(index);
    wr_addr  = AW'((wsum >= DEPTH_S) ? wsum - DEPTH_S : wsum);
    head_inc = AW'((hsum >= DEPTH_S) ? hsum - DEPTH_S : hsum);
    rd_addr  = AW'((rsum >= DEPTH_S) ? rsum - DEPTH_S : rsum);
    hit      = SW'(index) < SW'(fill);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      fill <= '0;
    end else if (cmd.clear) begin
      head <= '0;
      fill <= '0;
    end else if (cmd.append) begin
      if (full) begin
        head <= head_inc;
      end else begin
        fill <= fill + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.append) begin
      mem[wr_addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.read) begin
      rdata  <= mem[rd_addr];
      rd_hit <= hit;
    end
  end

  assign rd_level = rd_hit ? rdata : '0;

endmodule

@@ hw/rtl/audio_level_meter_history.sv @@
// ----------------------------------------------------------------------------
// audio_level_meter_history
// Mean absolute level meter: buffer means feed a running level, ticks append
// the level to a history ring that can be cleared or read back.
// ----------------------------------------------------------------------------
// channel  dir  handshake            word
// in       in   in_valid/in_ready    mode, sample, last_in_buffer, active,
//                                    entry_index
// out      out  out_valid/out_ready  kind, level, history_count
// cfg      in   cfg_valid/cfg_ready  cfg_data (max_history)
//
// A buffer close and an active tick with a nonzero count both use the 32-step
// shared divider; clear, read and a tick with a zero count go straight to the
// output stage. Read uses the history memory's registered port.
// Reset clears the meter's counters and the history head and fill; history
// memory and the divider's step counter are not cleared.
// A full output register holds back a pending result and stalls the input side.
// ----------------------------------------------------------------------------
module audio_level_meter_history
  import alm_pkg::*;
#(
  parameter int HISTORY_DEPTH = 256,
  parameter int BUFFER_MAX    = 4096
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 mode,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       last_in_buffer,
  input  logic                       active,
  input  logic [INDEX_W-1:0]         entry_index,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 kind,
  output logic [LEVEL_W-1:0]         level,
  output logic [COUNT_W-1:0]         history_count,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [COUNT_W-1:0]         cfg_data
);

  localparam int CNT_W = $clog2(BUFFER_MAX + 1);
  localparam int DVW   = (CNT_W > LCOUNT_W) ? CNT_W : LCOUNT_W;
  localparam int FW    = $clog2(HISTORY_DEPTH + 1);
  localparam logic [CNT_W-1:0]    BMAX  = CNT_W'(BUFFER_MAX);
  localparam logic [LCOUNT_W-1:0] LCMAX = '1;

  state_t state, state_next;

  logic [COUNT_W-1:0]  max_history;
  logic [SUM_W-1:0]    buffer_abs_sum;
  logic [CNT_W-1:0]    buffer_samples;
  logic [SUM_W-1:0]    level_sum;
  logic [LCOUNT_W-1:0] level_count;
  kind_t               res_kind;
  logic [LEVEL_W-1:0]  res_level;

  logic                in_fire;
  mode_t               in_mode;
  logic [LEVEL_W-1:0]  mag;
  logic [SUM_W-1:0]    abs_sum_next;
  logic [CNT_W-1:0]    samples_next;
  logic                close_go;
  logic                put_go;

  logic                div_start;
  logic [DIV_W-1:0]    div_dividend;
  logic [DVW-1:0]      div_divisor;
  logic                div_done;
  logic [DIV_W-1:0]    div_quotient;

  hist_cmd_t           hcmd;
  logic [LEVEL_W-1:0]  hist_wdata;
  logic [LEVEL_W-1:0]  rd_level;
  logic [FW-1:0]       hist_fill;

  assign in_fire   = in_valid && in_ready;
  assign in_mode   = mode_t'(mode);
  assign cfg_ready = 1'b1;
  assign put_go    = !out_valid || out_ready;

  always_comb begin
    mag = sample[SAMPLE_W-1] ? LEVEL_W'(~sample + 1'b1) : LEVEL_W'(sample);
    if (buffer_samples < BMAX) begin
      abs_sum_next = buffer_abs_sum + SUM_W'(mag);
      samples_next = buffer_samples + 1'b1;
    end else begin
      abs_sum_next = buffer_abs_sum;
      samples_next = buffer_samples;
    end
    close_go = last_in_buffer && samples_next != '0 && level_count != LCMAX;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          case (in_mode)
            MODE_SAMPLE: begin
              if (close_go) begin
                state_next = S_CLOSE;
              end
            end
            MODE_TICK: begin
              if (active) begin
                state_next = (level_count == '0) ? S_PUT : S_LEVEL;
              end
            end
            MODE_CLEAR, MODE_READ: begin
              state_next = S_PUT;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_CLOSE: begin
        if (div_done) begin
          state_next = S_IDLE;
        end
      end
      S_LEVEL: begin
        if (div_done) begin
          state_next = S_PUT;
        end
      end
      S_PUT: begin
        if (put_go) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = state == S_IDLE;
    div_start    = 1'b0;
    div_dividend = level_sum;
    div_divisor  = DVW'(level_count);
    hcmd         = '0;
    hist_wdata   = '0;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          case (in_mode)
            MODE_SAMPLE: begin
              div_start    = close_go;
              div_dividend = abs_sum_next;
              div_divisor  = DVW'(samples_next);
            end
            MODE_TICK: begin
              div_start   = active && level_count != '0;
              hcmd.append = active && level_count == '0;
            end
            MODE_CLEAR: hcmd.clear = 1'b1;
            MODE_READ:  hcmd.read  = 1'b1;
            default: ;
          endcase
        end
      end
      S_LEVEL: begin
        hcmd.append = div_done;
        hist_wdata  = div_quotient[LEVEL_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      max_history    <= COUNT_W'(MAXH_RESET);
      buffer_abs_sum <= '0;
      buffer_samples <= '0;
      level_sum      <= '0;
      level_count    <= '0;
      res_kind       <= KIND_APPEND;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        max_history <= cfg_data;
      end
      if (state == S_PUT && put_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            case (in_mode)
              MODE_SAMPLE: begin
                buffer_abs_sum <= last_in_buffer ? '0 : abs_sum_next;
                buffer_samples <= last_in_buffer ? '0 : samples_next;
              end
              MODE_TICK: begin
                if (active) begin
                  res_kind <= KIND_APPEND;
                end
              end
              MODE_CLEAR: res_kind <= KIND_CLEAR;
              MODE_READ:  res_kind <= KIND_READ;
              default: ;
            endcase
          end
        end
        S_CLOSE: begin
          if (div_done) begin
            level_sum   <= level_sum + div_quotient;
            level_count <= level_count + 1'b1;
          end
        end
        S_LEVEL: begin
          if (div_done) begin
            level_sum   <= '0;
            level_count <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_fire) begin
      res_level <= '0;
    end else if (state == S_LEVEL && div_done) begin
      res_level <= div_quotient[LEVEL_W-1:0];
    end
    if (state == S_PUT && put_go) begin
      kind          <= res_kind;
      level         <= (res_kind == KIND_READ) ? rd_level : res_level;
      history_count <= COUNT_W'(hist_fill);
    end
  end

  alm_div #(
    .DVW(DVW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  alm_hist #(
    .DEPTH(HISTORY_DEPTH)
  ) u_hist (
    .clk         (clk),
    .rst         (rst),
    .cmd         (hcmd),
    .wdata       (hist_wdata),
    .index       (entry_index),
    .max_history (max_history),
    .rd_level    (rd_level),
    .fill        (hist_fill)
  );

  a_hist_cmd_one: assert property (@(posedge clk) disable iff (rst)
    $onehot0({hcmd.append, hcmd.clear, hcmd.read}))
    else $error("history commands overlap");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_CLOSE || state == S_LEVEL))
    else $error("divider result with no consumer");

  a_put_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_PUT && put_go) |=> (out_valid && state == S_IDLE))
    else $error("result not loaded into output register");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    32'(hist_fill) <= 32'(HISTORY_DEPTH))
    else $error("history fill beyond depth");

  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> state == S_IDLE ##1 (state == S_CLOSE || state == S_LEVEL))
    else $error("divider started outside a division step");

endmodule
